FILE: rtl/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
// Used by sha1_ctrl, sha1_datapath and sha1_hash_engine_core; no dependencies.
package sha1_pkg;

  localparam int unsigned DigestWords = 5;
  localparam int unsigned Rounds      = 80;
  localparam int unsigned BlockWords  = 16;

  // byte slot where the 64-bit length field starts (448 bits into the block)
  localparam logic [5:0] LenPos = 6'(448 / 8);

  localparam logic [31:0] RoundK [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  localparam logic [31:0] InitChain [DigestWords] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_OUT
  } sha1_state_e;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } sha1_bsel_e;

  typedef struct packed {
    logic       put_byte;
    sha1_bsel_e byte_sel;
    logic       add_len;
    logic       load_vars;
    logic       round_en;
    logic [6:0] round_idx;
    logic       chain_add;
    logic       clear_msg;
    logic [2:0] out_idx;
  } sha1_cmd_t;

  typedef struct packed {
    logic [5:0] byte_pos;
  } sha1_stat_t;

endpackage

FILE: rtl/sha1_datapath.sv
// SHA-1 datapath: block buffer as a rolling word window, round variables,
// chaining value, length and byte position counters. Depends on sha1_pkg.
module sha1_datapath import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha1_cmd_t   cmd_i,
  input  logic [7:0]  msg_byte_i,
  output sha1_stat_t  stat_o,
  output logic [31:0] digest_word_o
);

  logic [31:0] win_q  [BlockWords];
  logic [31:0] win_d  [BlockWords];
  logic [31:0] vars_q [DigestWords];
  logic [31:0] vars_d [DigestWords];
  logic [31:0] chain_q [DigestWords];
  logic [31:0] chain_d [DigestWords];
  logic [63:0] bit_len_q, bit_len_d;
  logic [5:0]  byte_pos_q, byte_pos_d;

  logic [7:0]  byte_in;
  logic [63:0] len_shift;
  logic [31:0] w_sched, w_t, f_val, k_val, tmp;
  logic [1:0]  stage;

  assign stat_o.byte_pos = byte_pos_q;

  // length bytes go out most significant first
  assign len_shift = bit_len_q << {byte_pos_q[2:0], 3'b000};

  always_comb begin
    case (cmd_i.byte_sel)
      SEL_MSG:   byte_in = msg_byte_i;
      SEL_PAD80: byte_in = 8'h80;
      SEL_LEN:   byte_in = len_shift[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  always_comb begin
    if (cmd_i.round_idx < 7'd20) begin
      stage = 2'd0;
    end else if (cmd_i.round_idx < 7'd40) begin
      stage = 2'd1;
    end else if (cmd_i.round_idx < 7'd60) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end
  end

  // window slot 0 holds W[t-16]; taps at 13, 8, 2, 0 give W[t-3], W[t-8], W[t-14], W[t-16]
  assign w_sched = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign w_t     = (cmd_i.round_idx < 7'(BlockWords)) ? win_q[0]
                                                      : {w_sched[30:0], w_sched[31]};

  always_comb begin
    case (stage)
      2'd0:    f_val = (vars_q[1] & vars_q[2]) ^ (~vars_q[1] & vars_q[3]);
      2'd2:    f_val = (vars_q[1] & vars_q[2]) ^ (vars_q[1] & vars_q[3])
                     ^ (vars_q[2] & vars_q[3]);
      default: f_val = vars_q[1] ^ vars_q[2] ^ vars_q[3];
    endcase
  end

  assign k_val = RoundK[stage];
  assign tmp   = {vars_q[0][26:0], vars_q[0][31:27]} + f_val + vars_q[4] + k_val + w_t;

  always_comb begin
    win_d = win_q;
    if (cmd_i.put_byte) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[BlockWords-1] = {win_q[BlockWords-1][23:0], byte_in};
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[BlockWords-1] = w_t;
    end
  end

  always_comb begin
    vars_d = vars_q;
    if (cmd_i.load_vars) begin
      vars_d = chain_q;
    end else if (cmd_i.round_en) begin
      vars_d[0] = tmp;
      vars_d[1] = vars_q[0];
      vars_d[2] = {vars_q[1][1:0], vars_q[1][31:2]};
      vars_d[3] = vars_q[2];
      vars_d[4] = vars_q[3];
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (cmd_i.clear_msg) begin
      chain_d = InitChain;
    end else if (cmd_i.chain_add) begin
      for (int i = 0; i < DigestWords; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
      end
    end
  end

  always_comb begin
    bit_len_d  = bit_len_q;
    byte_pos_d = byte_pos_q;
    if (cmd_i.clear_msg) begin
      bit_len_d = '0;
    end else if (cmd_i.add_len) begin
      bit_len_d = bit_len_q + 64'd8;
    end
    if (cmd_i.put_byte) begin
      byte_pos_d = byte_pos_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    vars_q <= vars_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q    <= InitChain;
      bit_len_q  <= '0;
      byte_pos_q <= '0;
    end else begin
      chain_q    <= chain_d;
      bit_len_q  <= bit_len_d;
      byte_pos_q <= byte_pos_d;
    end
  end

  assign digest_word_o = chain_q[cmd_i.out_idx];

endmodule

FILE: rtl/sha1_ctrl.sv
// SHA-1 controller: accepts bytes, sequences padding, 80 rounds, chaining update
// and digest word output. Depends on sha1_pkg; drives sha1_datapath by commands.
module sha1_ctrl import sha1_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       has_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  sha1_stat_t stat_i,
  output sha1_cmd_t  cmd_o
);

  localparam logic [6:0] LastRound = 7'(Rounds - 1);
  localparam logic [2:0] LastWord  = 3'(DigestWords - 1);

  sha1_state_e state_q, state_d;
  logic [6:0]  round_q, round_d;
  logic [2:0]  word_q, word_d;
  logic        pad_mode_q, pad_mode_d;
  logic        pad_first_q, pad_first_d;
  logic        len_phase_q, len_phase_d;
  logic        final_q, final_d;

  logic block_full;
  logic hits_len;

  assign block_full = (stat_i.byte_pos == 6'd63);
  assign hits_len   = ((stat_i.byte_pos + 6'd1) == LenPos);

  // next state
  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    word_d      = word_q;
    pad_mode_d  = pad_mode_q;
    pad_first_d = pad_first_q;
    len_phase_d = len_phase_q;
    final_d     = final_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (has_byte_i || end_of_message_i)) begin
          pad_first_d = 1'b1;
          len_phase_d = 1'b0;
          final_d     = 1'b0;
          pad_mode_d  = end_of_message_i;
          if (has_byte_i && block_full) begin
            state_d = ST_ROUND;
            round_d = '0;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        pad_first_d = 1'b0;
        if (block_full) begin
          state_d = ST_ROUND;
          round_d = '0;
          final_d = len_phase_q;
        end else if (hits_len) begin
          len_phase_d = 1'b1;
        end
      end
      ST_ROUND: begin
        if (round_q == LastRound) begin
          state_d = ST_UPDATE;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      ST_UPDATE: begin
        if (final_q) begin
          state_d = ST_OUT;
          word_d  = '0;
        end else if (pad_mode_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (word_q == LastWord) begin
            state_d    = ST_IDLE;
            pad_mode_d = 1'b0;
            final_d    = 1'b0;
          end else begin
            word_d = word_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_sel  = SEL_MSG;
    cmd_o.round_idx = round_q;
    cmd_o.out_idx   = word_q;
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && has_byte_i) begin
          cmd_o.put_byte  = 1'b1;
          cmd_o.add_len   = 1'b1;
          cmd_o.load_vars = block_full;
        end
      end
      ST_PAD: begin
        cmd_o.put_byte  = 1'b1;
        cmd_o.load_vars = block_full;
        if (pad_first_q) begin
          cmd_o.byte_sel = SEL_PAD80;
        end else if (len_phase_q) begin
          cmd_o.byte_sel = SEL_LEN;
        end else begin
          cmd_o.byte_sel = SEL_ZERO;
        end
      end
      ST_ROUND:  cmd_o.round_en = 1'b1;
      ST_UPDATE: cmd_o.chain_add = 1'b1;
      ST_OUT: begin
        out_valid_o     = 1'b1;
        cmd_o.clear_msg = out_ready_i && (word_q == LastWord);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      round_q     <= '0;
      word_q      <= '0;
      pad_mode_q  <= 1'b0;
      pad_first_q <= 1'b0;
      len_phase_q <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      word_q      <= word_d;
      pad_mode_q  <= pad_mode_d;
      pad_first_q <= pad_first_d;
      len_phase_q <= len_phase_d;
      final_q     <= final_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output handshakes active together");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (round_q <= LastRound))
    else $error("round counter out of range");

  a_load_starts_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_vars |=> (state_q == ST_ROUND) && (round_q == '0))
    else $error("round variables loaded without starting a block");

  a_last_word_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && (word_q == LastWord)) |=> (state_q == ST_IDLE))
    else $error("engine not idle after last digest word");

  a_out_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) && !final_q |=> !out_valid_o)
    else $error("digest shown before final block");

endmodule

FILE: rtl/sha1_hash_engine_core.sv
// SHA-1 hash engine top level: joins the controller and the datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one transaction
//   per message byte; has_byte marks a data byte and end_of_message closes the
//   message after that byte. A transaction with neither bit set is ignored.
//   Output channel (out_valid_o / out_ready_i / out_data_o) carries the five
//   digest words, word_index 0 first, last_word set on word 4.
// Timing:
//   The 64th byte of a block starts the SHA-1 rounds (one SHA-1 round per
//   cycle) and then the chaining update, during which no input is taken.
//   End of message adds the padding bytes and one or two block
//   computations before word 0 appears; words then go one per cycle
//   while out_ready_i is high.
// Reset clears the chaining value to the SHA-1 initial values and zeroes the
// length and byte position. While the receiver stalls, the current digest word
// holds and no new input is taken; after word 4 the engine starts a new message.
module sha1_hash_engine_core import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sha1_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sha1_out_t out_data_o
);

  sha1_cmd_t   cmd;
  sha1_stat_t  stat;
  logic [31:0] digest_word;

  sha1_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .has_byte_i       (in_data_i.has_byte),
    .end_of_message_i (in_data_i.end_of_message),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .stat_i           (stat),
    .cmd_o            (cmd)
  );

  sha1_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_byte_i    (in_data_i.msg_byte),
    .stat_o        (stat),
    .digest_word_o (digest_word)
  );

  assign out_data_o.digest_word = digest_word;
  assign out_data_o.word_index  = cmd.out_idx;
  assign out_data_o.last_word   = (cmd.out_idx == 3'(DigestWords - 1));

endmodule
